// ===== rtl/mmq_pkg.sv =====
// Shared types and codes for the mailbox message queue engine.
`timescale 1ns / 1ps
`default_nettype none
package mmq_pkg;

  localparam int ENTRY_W = 53;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  typedef enum logic [1:0] {
    RESP_SENT    = 2'd0,
    RESP_RECV    = 2'd1,
    RESP_BLOCKED = 2'd2,
    RESP_FULL    = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_WB
  } state_t;

  typedef struct packed {
    logic cap;
    logic mul;
    logic fix;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/mmq_ctrl.sv =====
// Request sequencer: capture, time conversion, store read and writeback steps.
`timescale 1ns / 1ps
`default_nettype none
module mmq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire mmq_pkg::stat_t stat,
  output mmq_pkg::cmd_t       cmd
);

  mmq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mmq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = mmq_pkg::ST_MUL;
        end
      end
      mmq_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mmq_pkg::ST_FIX;
      end
      mmq_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = mmq_pkg::ST_WB;
      end
      mmq_pkg::ST_WB: begin
        if (!stat.out_full) begin
          cmd.wb    = 1'b1;
          state_nxt = mmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mmq_dp.sv =====
// Datapath: mailbox pointers, message and waiter stores, seconds conversion, result register.
`timescale 1ns / 1ps
`default_nettype none
module mmq_dp #(
  parameter int NUM_MAILBOXES    = 16,
  parameter int MBOX_DEPTH       = 16,
  parameter int PID_COUNT        = 32,
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mmq_pkg::cmd_t cmd,
  output mmq_pkg::stat_t     stat,
  input  wire logic          in_req_type,
  input  wire logic [4:0]    in_caller_pid,
  input  wire logic [3:0]    in_mailbox_id,
  input  wire logic [31:0]   in_payload,
  input  wire logic [31:0]   in_time_ticks,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  output logic [1:0]         out_status,
  output logic               out_wake_valid,
  output logic [4:0]         out_woken_pid,
  output logic [31:0]        out_msg_payload,
  output logic [4:0]         out_msg_sender,
  output logic [15:0]        out_msg_time_sent,
  output logic [15:0]        out_msg_time_received
);

  localparam int MBW = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
  localparam int DW  = $clog2(MBOX_DEPTH);
  localparam int CW  = $clog2(MBOX_DEPTH + 1);
  localparam int PW  = $clog2(PID_COUNT);
  localparam int WCW = $clog2(PID_COUNT + 1);
  localparam int AW  = MBW + DW;
  localparam int WAW = MBW + PW;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICKS_PER_SECOND);
  localparam logic [31:0] RATE  = 32'(TICKS_PER_SECOND);

  logic [MBW-1:0] mb_map [16];
  for (genvar g = 0; g < 16; g++) begin : g_mb_map
    assign mb_map[g] = MBW'(g % NUM_MAILBOXES);
  end

  logic [DW-1:0]  msg_head_r  [NUM_MAILBOXES];
  logic [DW-1:0]  msg_tail_r  [NUM_MAILBOXES];
  logic [CW-1:0]  msg_count_r [NUM_MAILBOXES];
  logic [PW-1:0]  wait_head_r [NUM_MAILBOXES];
  logic [WCW-1:0] wait_count_r[NUM_MAILBOXES];

  logic [mmq_pkg::ENTRY_W-1:0] msg_mem  [2**AW];
  logic [4:0]                  wait_mem [2**WAW];

  logic           req_r;
  logic [4:0]     pid_r;
  logic [MBW-1:0] mb_r;
  logic [31:0]    body_r;
  logic [31:0]    ticks_r;
  logic [31:0]    qest_r;
  logic [15:0]    now_r;
  logic [DW-1:0]  hd_r, tl_r;
  logic [CW-1:0]  cnt_r;
  logic [PW-1:0]  whd_r;
  logic [WCW-1:0] wcnt_r;
  logic [mmq_pkg::ENTRY_W-1:0] rd_msg_r;
  logic [4:0]     rd_wait_r;

  logic           out_valid_r;
  logic [1:0]     status_r, status_nxt;
  logic           wake_r, wake_nxt;
  logic [4:0]     woken_r, woken_nxt;
  logic [31:0]    mpay_r, mpay_nxt;
  logic [4:0]     msnd_r, msnd_nxt;
  logic [15:0]    msent_r, msent_nxt;
  logic [15:0]    mrecv_r, mrecv_nxt;

  logic [DW-1:0]  hd_nxt, tl_nxt, hd_inc, tl_inc;
  logic [CW-1:0]  cnt_nxt;
  logic [PW-1:0]  whd_nxt, whd_inc, slot;
  logic [WCW-1:0] wcnt_nxt;
  logic [PW:0]    slot_sum;
  logic           msg_we, wait_we;
  logic [63:0]    prod;
  logic [63:0]    back;
  logic [31:0]    rem;

  // seconds = ticks / rate: reciprocal multiply, then one correction step
  assign prod = ticks_r * RECIP[31:0];
  assign back = qest_r * RATE;
  assign rem  = ticks_r - back[31:0];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r   <= in_req_type;
      pid_r   <= in_caller_pid;
      mb_r    <= mb_map[in_mailbox_id];
      body_r  <= in_payload;
      ticks_r <= in_time_ticks;
    end
    if (cmd.mul) begin
      qest_r <= (TICKS_PER_SECOND == 1) ? ticks_r : prod[63:32];
      hd_r   <= msg_head_r[mb_r];
      tl_r   <= msg_tail_r[mb_r];
      cnt_r  <= msg_count_r[mb_r];
      whd_r  <= wait_head_r[mb_r];
      wcnt_r <= wait_count_r[mb_r];
    end
    if (cmd.fix) begin
      now_r <= (rem >= RATE) ? 16'(qest_r + 32'd1) : qest_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rd_msg_r  <= msg_mem[{mb_r, msg_head_r[mb_r]}];
      rd_wait_r <= wait_mem[{mb_r, wait_head_r[mb_r]}];
    end
    if (msg_we) begin
      msg_mem[{mb_r, tl_r}] <= {now_r, pid_r, body_r};
    end
    if (wait_we) begin
      wait_mem[{mb_r, slot}] <= pid_r;
    end
  end

  assign hd_inc   = (hd_r == DW'(MBOX_DEPTH - 1)) ? '0 : hd_r + 1'b1;
  assign tl_inc   = (tl_r == DW'(MBOX_DEPTH - 1)) ? '0 : tl_r + 1'b1;
  assign whd_inc  = (whd_r == PW'(PID_COUNT - 1)) ? '0 : whd_r + 1'b1;
  assign slot_sum = {1'b0, whd_r} + (PW + 1)'(wcnt_r);
  assign slot     = (slot_sum >= (PW + 1)'(PID_COUNT)) ?
                    PW'(slot_sum - (PW + 1)'(PID_COUNT)) : slot_sum[PW-1:0];

  always_comb begin
    hd_nxt     = hd_r;
    tl_nxt     = tl_r;
    cnt_nxt    = cnt_r;
    whd_nxt    = whd_r;
    wcnt_nxt   = wcnt_r;
    msg_we     = 1'b0;
    wait_we    = 1'b0;
    status_nxt = mmq_pkg::RESP_SENT;
    wake_nxt   = 1'b0;
    woken_nxt  = '0;
    mpay_nxt   = '0;
    msnd_nxt   = '0;
    msent_nxt  = '0;
    mrecv_nxt  = '0;
    if (req_r == mmq_pkg::REQ_SEND) begin
      if (cnt_r == CW'(MBOX_DEPTH)) begin
        status_nxt = mmq_pkg::RESP_FULL;
      end else if (wcnt_r != '0) begin
        // a waiter implies an empty mailbox, so the head is the new message
        hd_nxt    = hd_inc;
        tl_nxt    = tl_inc;
        whd_nxt   = whd_inc;
        wcnt_nxt  = wcnt_r - 1'b1;
        wake_nxt  = 1'b1;
        woken_nxt = rd_wait_r;
        mpay_nxt  = body_r;
        msnd_nxt  = pid_r;
        msent_nxt = now_r;
        mrecv_nxt = now_r;
      end else begin
        msg_we  = cmd.wb;
        tl_nxt  = tl_inc;
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      woken_nxt = pid_r;
      if (cnt_r != '0) begin
        status_nxt = mmq_pkg::RESP_RECV;
        hd_nxt     = hd_inc;
        cnt_nxt    = cnt_r - 1'b1;
        mpay_nxt   = rd_msg_r[31:0];
        msnd_nxt   = rd_msg_r[36:32];
        msent_nxt  = rd_msg_r[52:37];
        mrecv_nxt  = now_r;
      end else begin
        status_nxt = mmq_pkg::RESP_BLOCKED;
        if (wcnt_r != WCW'(PID_COUNT)) begin
          wait_we  = cmd.wb;
          wcnt_nxt = wcnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MAILBOXES; i++) begin
        msg_head_r[i]   <= '0;
        msg_tail_r[i]   <= '0;
        msg_count_r[i]  <= '0;
        wait_head_r[i]  <= '0;
        wait_count_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wb) begin
        msg_head_r[mb_r]   <= hd_nxt;
        msg_tail_r[mb_r]   <= tl_nxt;
        msg_count_r[mb_r]  <= cnt_nxt;
        wait_head_r[mb_r]  <= whd_nxt;
        wait_count_r[mb_r] <= wcnt_nxt;
        out_valid_r        <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      status_r <= status_nxt;
      wake_r   <= wake_nxt;
      woken_r  <= woken_nxt;
      mpay_r   <= mpay_nxt;
      msnd_r   <= msnd_nxt;
      msent_r  <= msent_nxt;
      mrecv_r  <= mrecv_nxt;
    end
  end

  assign stat.out_full         = out_valid_r && !out_tready;
  assign out_tvalid            = out_valid_r;
  assign out_status            = status_r;
  assign out_wake_valid        = wake_r;
  assign out_woken_pid         = woken_r;
  assign out_msg_payload       = mpay_r;
  assign out_msg_sender        = msnd_r;
  assign out_msg_time_sent     = msent_r;
  assign out_msg_time_received = mrecv_r;

endmodule
`default_nettype wire

// ===== rtl/mailbox_message_queue_engine_unit.sv =====
// A request steps through the two-multiply seconds conversion and registered store read,
// then writeback, which waits while the result register is stalled; out_tvalid rises
// after writeback, and no new request is taken until that writeback is done.
// Reset: mailbox and waiter pointers and counts clear; message and waiter stores
// are not cleared and need no sweep, so a request is taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
module mailbox_message_queue_engine_unit #(
  parameter int NUM_MAILBOXES    = 16,
  parameter int MBOX_DEPTH       = 16,
  parameter int PID_COUNT        = 32,
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,  // caller_pid, mailbox_id, payload, time_ticks, zero pad
  input  wire logic [0:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // woken_pid, msg_payload, msg_sender, msg_time_sent, msg_time_received, zero pad
  output logic [79:0]      out_tdata,
  output logic [2:0]       out_tuser  // status, wake_valid
);

  mmq_pkg::cmd_t  cmd;
  mmq_pkg::stat_t stat;

  logic [1:0]  status;
  logic        wake_valid;
  logic [4:0]  woken_pid;
  logic [31:0] msg_payload;
  logic [4:0]  msg_sender;
  logic [15:0] msg_time_sent;
  logic [15:0] msg_time_received;

  mmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmq_dp #(
    .NUM_MAILBOXES    (NUM_MAILBOXES),
    .MBOX_DEPTH       (MBOX_DEPTH),
    .PID_COUNT        (PID_COUNT),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_req_type           (in_tuser[0]),
    .in_caller_pid         (in_tdata[4:0]),
    .in_mailbox_id         (in_tdata[8:5]),
    .in_payload            (in_tdata[40:9]),
    .in_time_ticks         (in_tdata[72:41]),
    .out_tready            (out_tready),
    .out_tvalid            (out_tvalid),
    .out_status            (status),
    .out_wake_valid        (wake_valid),
    .out_woken_pid         (woken_pid),
    .out_msg_payload       (msg_payload),
    .out_msg_sender        (msg_sender),
    .out_msg_time_sent     (msg_time_sent),
    .out_msg_time_received (msg_time_received)
  );

  assign out_tdata = {6'b0, msg_time_received, msg_time_sent, msg_sender, msg_payload,
                      woken_pid};
  assign out_tuser = {wake_valid, status};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("request taken before previous one finished");

  a_wb_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> out_tvalid)
    else $error("writeback did not present a result");

  a_wb_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !(out_tvalid && !out_tready))
    else $error("writeback overwrote a pending result");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the mailbox message queue engine: random and directed requests.
`timescale 1ns / 1ps
module testbench;

  localparam int NBOX     = 16;
  localparam int DEPTH    = 16;
  localparam int PIDS     = 32;
  localparam int TPS      = 100;
  localparam int LIMIT    = 200000;
  localparam int RAND_REQS = 600;

  typedef struct packed {
    logic        kind;
    logic [4:0]  pid;
    logic [3:0]  mbox;
    logic [31:0] payload;
    logic [31:0] ticks;
  } mbox_req_t;

  typedef struct packed {
    mmq_pkg::resp_t status;
    logic        wake;
    logic [4:0]  pid;
    logic [31:0] payload;
    logic [4:0]  sender;
    logic [15:0] sent;
    logic [15:0] rcvd;
  } delivery_t;

  typedef struct packed {
    logic [31:0] payload;
    logic [4:0]  sender;
    logic [15:0] sent;
  } stored_msg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // caller_pid, mailbox_id, payload, time_ticks, zero pad
  logic [0:0]  in_tuser = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // woken_pid, msg_payload, msg_sender, msg_time_sent,
                                // msg_time_received, zero pad
  logic [2:0]  out_tuser;       // status, wake_valid

  mailbox_message_queue_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  mbox_req_t   pending_reqs[$];
  delivery_t   expected_deliveries[$];
  mbox_req_t   next_req;
  int          total_reqs;
  int          words_accepted;
  int          words_checked;
  int          errors;
  int          cycle_count;
  int          n_sent, n_recv, n_blocked, n_full, n_woken, n_dropped;
  logic        calm;

  // predictor state
  stored_msg_t msg_mem  [NBOX][DEPTH];
  logic [3:0]  msg_rd   [NBOX];
  logic [3:0]  msg_wr   [NBOX];
  logic [4:0]  msg_cnt  [NBOX];
  logic [4:0]  wait_mem [NBOX][PIDS];
  logic [4:0]  wait_rd  [NBOX];
  logic [5:0]  wait_cnt [NBOX];

  assign calm = (words_accepted >= 250) && (words_accepted < 400);

  task automatic add_req(input logic kind, input logic [4:0] pid, input logic [3:0] mbox,
                         input logic [31:0] payload, input logic [31:0] ticks);
    mbox_req_t r;
    r.kind    = kind;
    r.pid     = pid;
    r.mbox    = mbox;
    r.payload = payload;
    r.ticks   = ticks;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(input logic kind, input logic [3:0] mbox);
    add_req(kind, 5'($urandom_range(0, 31)), mbox, $urandom(), $urandom());
  endtask

  function automatic void predict_mailbox_op(input mbox_req_t r);
    delivery_t   d;
    stored_msg_t m;
    int          mb;
    logic [15:0] now;
    mb  = int'(r.mbox) % NBOX;
    now = 16'(r.ticks / TPS);
    d   = '0;
    if (r.kind == mmq_pkg::REQ_SEND) begin
      if (msg_cnt[mb] >= DEPTH) begin
        d.status = mmq_pkg::RESP_FULL;
        n_full++;
      end else begin
        msg_mem[mb][msg_wr[mb]] = '{payload: r.payload, sender: r.pid, sent: now};
        msg_wr[mb]  = 4'((msg_wr[mb] + 1) % DEPTH);
        msg_cnt[mb] = msg_cnt[mb] + 1;
        d.status = mmq_pkg::RESP_SENT;
        n_sent++;
        if (wait_cnt[mb] > 0) begin
          d.wake = 1'b1;
          d.pid  = wait_mem[mb][wait_rd[mb]];
          wait_rd[mb]  = 5'((wait_rd[mb] + 1) % PIDS);
          wait_cnt[mb] = wait_cnt[mb] - 1;
          m = msg_mem[mb][msg_rd[mb]];
          msg_rd[mb]  = 4'((msg_rd[mb] + 1) % DEPTH);
          msg_cnt[mb] = msg_cnt[mb] - 1;
          d.payload = m.payload;
          d.sender  = m.sender;
          d.sent    = m.sent;
          d.rcvd    = now;
          n_woken++;
        end
      end
    end else begin
      d.pid = r.pid;
      if (msg_cnt[mb] > 0) begin
        m = msg_mem[mb][msg_rd[mb]];
        msg_rd[mb]  = 4'((msg_rd[mb] + 1) % DEPTH);
        msg_cnt[mb] = msg_cnt[mb] - 1;
        d.status  = mmq_pkg::RESP_RECV;
        d.payload = m.payload;
        d.sender  = m.sender;
        d.sent    = m.sent;
        d.rcvd    = now;
        n_recv++;
      end else begin
        d.status = mmq_pkg::RESP_BLOCKED;
        n_blocked++;
        if (wait_cnt[mb] < PIDS) begin
          wait_mem[mb][5'((wait_rd[mb] + wait_cnt[mb]) % PIDS)] = r.pid;
          wait_cnt[mb] = wait_cnt[mb] + 1;
        end else begin
          n_dropped++;
        end
      end
    end
    expected_deliveries.push_back(d);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("word %0d: %s expected 0x%0h, got 0x%0h", words_checked, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
        next_req  = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_req.kind;
        in_tdata  <= {7'b0, next_req.ticks, next_req.payload, next_req.mbox, next_req.pid};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // monitor
  always @(posedge clk) begin
    delivery_t d;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_deliveries.size() == 0) begin
        $error("unexpected result word: tuser 0x%0h tdata 0x%0h", out_tuser, out_tdata);
        errors++;
      end else begin
        d = expected_deliveries.pop_front();
        check_field("status", 32'(d.status), 32'(out_tuser[1:0]));
        check_field("wake_valid", 32'(d.wake), 32'(out_tuser[2]));
        check_field("woken_pid", 32'(d.pid), 32'(out_tdata[4:0]));
        check_field("msg_payload", d.payload, out_tdata[36:5]);
        check_field("msg_sender", 32'(d.sender), 32'(out_tdata[41:37]));
        check_field("msg_time_sent", 32'(d.sent), 32'(out_tdata[57:42]));
        check_field("msg_time_received", 32'(d.rcvd), 32'(out_tdata[73:58]));
        check_field("pad", 32'h0, 32'(out_tdata[79:74]));
      end
      words_checked++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_mailbox_op(mbox_req_t'({in_tuser[0], in_tdata[4:0], in_tdata[8:5],
                                      in_tdata[40:9], in_tdata[72:41]}));
      words_accepted++;
    end
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d of %0d words accepted",
             cycle_count, words_accepted, total_reqs);
    $display("mailbox_message_queue_engine_unit verification failed");
    $finish;
  end

  initial begin
    int n;
    int pick;
    int mb;
    int len;
    words_accepted = 0;
    words_checked  = 0;
    errors         = 0;
    cycle_count    = 0;
    {n_sent, n_recv, n_blocked, n_full, n_woken, n_dropped} = '0;
    for (int i = 0; i < NBOX; i++) begin
      msg_rd[i]   = '0;
      msg_wr[i]   = '0;
      msg_cnt[i]  = '0;
      wait_rd[i]  = '0;
      wait_cnt[i] = '0;
    end

    // directed: block then wake, plain send and receive, field extremes
    add_req(mmq_pkg::REQ_RECV, 5'd31, 4'd0, 32'h0, 32'h0);
    add_req(mmq_pkg::REQ_SEND, 5'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(mmq_pkg::REQ_SEND, 5'd31, 4'd0, 32'h0, 32'h0);
    add_req(mmq_pkg::REQ_RECV, 5'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the top mailbox, overflow it, then wrap the ring
    for (int i = 0; i < DEPTH; i++)
      add_req(mmq_pkg::REQ_SEND, 5'(i), 4'd15, 32'hA5A5_0000 + i, 32'(i * 6553700));
    add_req(mmq_pkg::REQ_SEND, 5'd7, 4'd15, 32'h5A5A_5A5A, 32'h0123_4567);
    add_req(mmq_pkg::REQ_RECV, 5'd3, 4'd15, 32'h0, 32'h89AB_CDEF);
    add_req(mmq_pkg::REQ_SEND, 5'd9, 4'd15, 32'hDEAD_BEEF, 32'hFFFF_FF00);

    n = 0;
    while (n < RAND_REQS) begin
      pick = $urandom_range(0, 9);
      mb   = $urandom_range(0, 3);
      if (pick <= 3) begin
        len = 10;
        for (int i = 0; i < len; i++) add_random(1'($urandom_range(0, 1)), 4'(mb));
      end else if (pick == 4) begin
        len = $urandom_range(14, 18);
        for (int i = 0; i < len; i++) add_random(mmq_pkg::REQ_SEND, 4'(mb));
      end else if (pick == 5) begin
        len = $urandom_range(14, 18);
        for (int i = 0; i < len; i++) add_random(mmq_pkg::REQ_RECV, 4'(mb));
      end else if (pick == 6 && $urandom_range(0, 2) == 0) begin
        // overrun the waiter queue, then wake everyone
        mb  = $urandom_range(0, 15);
        len = $urandom_range(33, 36);
        for (int i = 0; i < DEPTH + len; i++) add_random(mmq_pkg::REQ_RECV, 4'(mb));
        for (int i = 0; i < len; i++) add_random(mmq_pkg::REQ_SEND, 4'(mb));
        len = DEPTH + 2 * len;
      end else begin
        len = 8;
        for (int i = 0; i < len; i++)
          add_random(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
      n += len;
    end
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_accepted == total_reqs);
    wait (expected_deliveries.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_deliveries.size() != 0) begin
      $error("%0d results never arrived", expected_deliveries.size());
      errors++;
    end

    $display("%0d requests: %0d sends stored, %0d receives served, %0d blocked, %0d full",
             total_reqs, n_sent, n_recv, n_blocked, n_full);
    $display("%0d receivers woken by sends, %0d waits dropped on a full waiter queue",
             n_woken, n_dropped);
    if (errors == 0) begin
      $display("mailbox_message_queue_engine_unit verification clean");
    end else begin
      $display("mailbox_message_queue_engine_unit verification failed");
    end
    $finish;
  end

endmodule
